FILE: rtl/kgrq_pkg.sv
// ----------------------------------------------------------------------------
// kgrq_pkg
// Shared constants, codes and controller/datapath bundles for the keypoint
// grid radius query block.
// ----------------------------------------------------------------------------
package kgrq_pkg;

  // default sizes
  localparam int GRID_COLS_DEF     = 64;
  localparam int GRID_ROWS_DEF     = 48;
  localparam int CELL_CAPACITY_DEF = 16;
  localparam int MAX_KEYPOINTS_DEF = 2048;
  localparam int MAX_HITS_DEF      = 64;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // insert status codes
  localparam logic [1:0] ST_STORED     = 2'd0;
  localparam logic [1:0] ST_OUTSIDE    = 2'd1;
  localparam logic [1:0] ST_CELL_FULL  = 2'd2;
  localparam logic [1:0] ST_STORE_FULL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MIN_Y = 2'd1;
  localparam logic [1:0] REG_W_INV = 2'd2;
  localparam logic [1:0] REG_H_INV = 2'd3;

  // configuration reset values
  localparam logic [15:0] MIN_RST = 16'd0;
  localparam logic [15:0] INV_RST = 16'd6554;

  // multiplier operand selection
  localparam logic [3:0] MUL_X  = 4'd0;
  localparam logic [3:0] MUL_Y  = 4'd1;
  localparam logic [3:0] MUL_X0 = 4'd2;
  localparam logic [3:0] MUL_X1 = 4'd3;
  localparam logic [3:0] MUL_Y0 = 4'd4;
  localparam logic [3:0] MUL_Y1 = 4'd5;
  localparam logic [3:0] MUL_DX = 4'd6;
  localparam logic [3:0] MUL_DY = 4'd7;
  localparam logic [3:0] MUL_R  = 4'd8;

  // product capture targets
  localparam logic [3:0] CAP_NONE = 4'd0;
  localparam logic [3:0] CAP_CX   = 4'd1;
  localparam logic [3:0] CAP_CY   = 4'd2;
  localparam logic [3:0] CAP_C0X  = 4'd3;
  localparam logic [3:0] CAP_C1X  = 4'd4;
  localparam logic [3:0] CAP_C0Y  = 4'd5;
  localparam logic [3:0] CAP_C1Y  = 4'd6;
  localparam logic [3:0] CAP_R2   = 4'd7;
  localparam logic [3:0] CAP_DX2  = 4'd8;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic [3:0] mul_sel;
    logic [3:0] cap;
    logic       store_wr;
    logic       fill_rd;
    logic       ins_file;
    logic       idx_bump;
    logic       ent_rd;
    logic       e_next;
    logic       cell_next;
    logic       walk_init;
    logic       hit;
    logic       set_trunc;
    logic       emit_ins;
    logic [1:0] ins_status;
    logic       emit_end;
    logic       clr_start;
    logic       clr_step;
  } kgrq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic store_full;
    logic outside;
    logic cell_full;
    logic range_empty;
    logic ent_more;
    logic lvl_ok;
    logic in_radius;
    logic hits_full;
    logic walk_done;
    logic clr_done;
  } kgrq_stat_t;

endpackage

FILE: rtl/keypoint_grid_radius_query_top.sv
// ----------------------------------------------------------------------------
// keypoint_grid_radius_query_top
// Uniform grid index of keypoints for a left and a right camera with
// insert, clear and radius query items.
// ----------------------------------------------------------------------------
// An item transfers when start is high and busy is low; results appear one
// per cycle-long result_valid strobe and cannot be held off, so the receiver
// must take every one. The last result of an item is on the ports in the
// cycle in which busy is low again. After reset, and after every clear item,
// the block sweeps all 2*GRID_COLS*GRID_ROWS fill counts of both grids (6144
// by default), one cell a cycle, with busy high; configuration writes are
// taken at any time. An insert that finds its side's store full ends at the
// store check, and one that lies outside the grid ends after its cell number
// is formed. A query forms its cell range and squared radius on the shared
// multiplier, checks the range, walks the cells one entry at a time, tests
// each entry against the level bounds and then the distance, and closes with
// a final result; the single multiplier and the one-entry-at-a-time walk over
// the cell memories set its pace.
module keypoint_grid_radius_query_top #(
  parameter int GRID_COLS     = kgrq_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS     = kgrq_pkg::GRID_ROWS_DEF,
  parameter int CELL_CAPACITY = kgrq_pkg::CELL_CAPACITY_DEF,
  parameter int MAX_KEYPOINTS = kgrq_pkg::MAX_KEYPOINTS_DEF,
  parameter int MAX_HITS      = kgrq_pkg::MAX_HITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic               right_side,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic [2:0]         keypoint_level,
  input  logic [14:0]        radius,
  input  logic signed [3:0]  lowest_level,
  input  logic signed [3:0]  highest_level,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  output logic [1:0]         insert_status,
  output logic               found,
  output logic [10:0]        keypoint_index,
  output logic               last,
  output logic               truncated
);

  kgrq_pkg::kgrq_cmd_t  cmd;
  kgrq_pkg::kgrq_stat_t stat;

  // sequencer
  kgrq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and arithmetic
  kgrq_datapath #(
    .GRID_COLS     (GRID_COLS),
    .GRID_ROWS     (GRID_ROWS),
    .CELL_CAPACITY (CELL_CAPACITY),
    .MAX_KEYPOINTS (MAX_KEYPOINTS),
    .MAX_HITS      (MAX_HITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .right_side     (right_side),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .keypoint_level (keypoint_level),
    .radius         (radius),
    .lowest_level   (lowest_level),
    .highest_level  (highest_level),
    .cmd            (cmd),
    .stat           (stat),
    .result_valid   (result_valid),
    .insert_status  (insert_status),
    .found          (found),
    .keypoint_index (keypoint_index),
    .last           (last),
    .truncated      (truncated)
  );

endmodule

FILE: rtl/kgrq_datapath.sv
// ----------------------------------------------------------------------------
// kgrq_datapath
// Configuration registers, grid memories, keypoint store, shared multiplier,
// cell walk counters and result registers.
// ----------------------------------------------------------------------------
module kgrq_datapath #(
  parameter int GRID_COLS     = kgrq_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS     = kgrq_pkg::GRID_ROWS_DEF,
  parameter int CELL_CAPACITY = kgrq_pkg::CELL_CAPACITY_DEF,
  parameter int MAX_KEYPOINTS = kgrq_pkg::MAX_KEYPOINTS_DEF,
  parameter int MAX_HITS      = kgrq_pkg::MAX_HITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               right_side,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic [2:0]         keypoint_level,
  input  logic [14:0]        radius,
  input  logic signed [3:0]  lowest_level,
  input  logic signed [3:0]  highest_level,
  input  kgrq_pkg::kgrq_cmd_t  cmd,
  output kgrq_pkg::kgrq_stat_t stat,
  output logic               result_valid,
  output logic [1:0]         insert_status,
  output logic               found,
  output logic [10:0]        keypoint_index,
  output logic               last,
  output logic               truncated
);

  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int FDEPTH = 2 * NCELLS;
  localparam int FA     = $clog2(FDEPTH);
  localparam int EDEPTH = FDEPTH * CELL_CAPACITY;
  localparam int EA     = $clog2(EDEPTH);
  localparam int FW     = $clog2(CELL_CAPACITY + 1);
  localparam int IW     = $clog2(MAX_KEYPOINTS);
  localparam int NW     = $clog2(MAX_KEYPOINTS + 1);
  localparam int SDEPTH = 2 << IW;
  localparam int HW     = $clog2(MAX_HITS + 1);
  localparam logic signed [15:0] COL_LIM = 16'(GRID_COLS - 1);
  localparam logic signed [15:0] ROW_LIM = 16'(GRID_ROWS - 1);

  // configuration registers
  logic signed [15:0] min_x, min_y;
  logic [15:0]        w_inv, h_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= kgrq_pkg::MIN_RST;
      min_y <= kgrq_pkg::MIN_RST;
      w_inv <= kgrq_pkg::INV_RST;
      h_inv <= kgrq_pkg::INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kgrq_pkg::REG_MIN_X: min_x <= cfg_data;
        kgrq_pkg::REG_MIN_Y: min_y <= cfg_data;
        kgrq_pkg::REG_W_INV: w_inv <= cfg_data;
        kgrq_pkg::REG_H_INV: h_inv <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  logic               side;
  logic signed [15:0] qx, qy;
  logic [2:0]         lvl;
  logic [14:0]        rad;
  logic signed [3:0]  minl, maxl;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      side <= right_side;
      qx   <= x_pos;
      qy   <= y_pos;
      lvl  <= keypoint_level;
      rad  <= radius;
      minl <= lowest_level;
      maxl <= highest_level;
    end
  end

  // memories and their read registers
  logic [FW-1:0] fill_mem  [FDEPTH];
  logic [IW-1:0] entry_mem [EDEPTH];
  logic [34:0]   store_mem [SDEPTH];
  logic [FW-1:0] fill_q;
  logic [IW-1:0] entry_q;
  logic [34:0]   store_q;

  // shared multiplier
  logic signed [17:0] xs, ys, rs, mxs, mys, kxs, kys, mul_a, mul_b;
  logic signed [35:0] prod;
  logic signed [15:0] cell_v;

  assign xs  = {{2{qx[15]}}, qx};
  assign ys  = {{2{qy[15]}}, qy};
  assign rs  = {3'b000, rad};
  assign mxs = {{2{min_x[15]}}, min_x};
  assign mys = {{2{min_y[15]}}, min_y};
  assign kxs = {{2{store_q[15]}}, store_q[15:0]};
  assign kys = {{2{store_q[31]}}, store_q[31:16]};

  // operand selection
  always_comb begin
    case (cmd.mul_sel)
      kgrq_pkg::MUL_X:  begin mul_a = xs - mxs;      mul_b = {2'b00, w_inv}; end
      kgrq_pkg::MUL_Y:  begin mul_a = ys - mys;      mul_b = {2'b00, h_inv}; end
      kgrq_pkg::MUL_X0: begin mul_a = xs - rs - mxs; mul_b = {2'b00, w_inv}; end
      kgrq_pkg::MUL_X1: begin mul_a = xs + rs - mxs; mul_b = {2'b00, w_inv}; end
      kgrq_pkg::MUL_Y0: begin mul_a = ys - rs - mys; mul_b = {2'b00, h_inv}; end
      kgrq_pkg::MUL_Y1: begin mul_a = ys + rs - mys; mul_b = {2'b00, h_inv}; end
      kgrq_pkg::MUL_DX: begin mul_a = kxs - xs;      mul_b = kxs - xs;       end
      kgrq_pkg::MUL_DY: begin mul_a = kys - ys;      mul_b = kys - ys;       end
      default:          begin mul_a = rs;            mul_b = rs;             end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // floor division by 2^20 is an arithmetic shift
  assign cell_v = prod[35:20];

  // captured cell bounds and squares
  logic signed [15:0] c0x, c1x, c0y, c1y, ix, iy;
  logic [29:0]        r2;
  logic [33:0]        dx2;

  always_ff @(posedge clk) begin
    case (cmd.cap)
      kgrq_pkg::CAP_C0X: c0x <= cell_v[15] ? 16'sd0 : cell_v;
      kgrq_pkg::CAP_C1X: c1x <= (cell_v > COL_LIM) ? COL_LIM : cell_v;
      kgrq_pkg::CAP_C0Y: c0y <= cell_v[15] ? 16'sd0 : cell_v;
      kgrq_pkg::CAP_C1Y: c1y <= (cell_v > ROW_LIM) ? ROW_LIM : cell_v;
      kgrq_pkg::CAP_R2:  r2  <= prod[29:0];
      kgrq_pkg::CAP_DX2: dx2 <= prod[33:0];
      default: ;
    endcase
  end

  // cell coordinate counters, loaded by insert or walked by query
  always_ff @(posedge clk) begin
    if (cmd.cap == kgrq_pkg::CAP_CX) begin
      ix <= cell_v;
    end else if (cmd.cap == kgrq_pkg::CAP_CY) begin
      iy <= cell_v;
    end else if (cmd.walk_init) begin
      ix <= c0x;
      iy <= c0y;
    end else if (cmd.cell_next) begin
      if (iy < c1y) begin
        iy <= iy + 16'sd1;
      end else begin
        iy <= c0y;
        ix <= ix + 16'sd1;
      end
    end
  end

  // addresses
  logic [CW-1:0] cell_no;
  logic [FA-1:0] fill_addr;
  logic [EA-1:0] ent_wr_addr, ent_rd_addr;
  logic [FW-1:0] e;
  logic [FA-1:0] clr_addr;

  assign cell_no     = CW'(ix) * CW'(GRID_ROWS) + CW'(iy);
  assign fill_addr   = FA'(side) * FA'(NCELLS) + FA'(cell_no);
  assign ent_wr_addr = EA'(fill_addr) * EA'(CELL_CAPACITY) + EA'(fill_q);
  assign ent_rd_addr = EA'(fill_addr) * EA'(CELL_CAPACITY) + EA'(e);

  // keypoint index counters
  logic [NW-1:0] nidx [2];
  logic [NW-1:0] cur_idx;

  assign cur_idx = nidx[side];

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      nidx[0] <= '0;
      nidx[1] <= '0;
    end else if (cmd.idx_bump) begin
      nidx[side] <= cur_idx + NW'(1);
    end
  end

  // clearing sweep over fill counts
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + FA'(1);
    end
  end

  // fill count memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      fill_mem[clr_addr] <= '0;
    end else if (cmd.ins_file) begin
      fill_mem[fill_addr] <= fill_q + FW'(1);
    end
    if (cmd.fill_rd) begin
      fill_q <= fill_mem[fill_addr];
    end
  end

  // cell entry memory
  always_ff @(posedge clk) begin
    if (cmd.ins_file) begin
      entry_mem[ent_wr_addr] <= cur_idx[IW-1:0];
    end
    if (cmd.ent_rd) begin
      entry_q <= entry_mem[ent_rd_addr];
    end
  end

  // keypoint store: level, y, x
  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store_mem[{side, cur_idx[IW-1:0]}] <= {lvl, qy, qx};
    end
    store_q <= store_mem[{side, entry_q}];
  end

  // entry counter within a cell
  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      e <= '0;
    end else if (cmd.e_next) begin
      e <= e + FW'(1);
    end
  end

  // hit bookkeeping, one hit held back so the final one can carry last
  logic [HW-1:0] n;
  logic [IW-1:0] pend;
  logic          trunc;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      n     <= '0;
      trunc <= 1'b0;
    end else begin
      if (cmd.hit) begin
        n    <= n + HW'(1);
        pend <= entry_q;
      end
      if (cmd.set_trunc) begin
        trunc <= 1'b1;
      end
    end
  end

  // status
  logic [34:0] dist2;
  assign dist2 = {1'b0, dx2} + {1'b0, prod[33:0]};

  always_comb begin
    stat.store_full  = (cur_idx >= NW'(MAX_KEYPOINTS));
    stat.outside     = ix[15] || (ix > COL_LIM) || iy[15] || (iy > ROW_LIM);
    stat.cell_full   = (fill_q >= FW'(CELL_CAPACITY));
    stat.range_empty = (c0x > c1x) || (c0y > c1y);
    stat.ent_more    = (e < fill_q);
    stat.lvl_ok      = (minl[3] || (store_q[34:32] >= minl[2:0])) &&
                       (maxl[3] || (store_q[34:32] <= maxl[2:0]));
    stat.in_radius   = (dist2 < {5'b00000, r2});
    stat.hits_full   = (n >= HW'(MAX_HITS));
    stat.walk_done   = (ix == c1x) && (iy == c1y);
    stat.clr_done    = (clr_addr == FA'(FDEPTH - 1));
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_ins || cmd.emit_end || (cmd.hit && (n != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ins) begin
      insert_status  <= cmd.ins_status;
      found          <= 1'b0;
      keypoint_index <= (cmd.ins_status == kgrq_pkg::ST_STORE_FULL) ? 11'd0 : 11'(cur_idx);
      last           <= 1'b1;
      truncated      <= 1'b0;
    end else if (cmd.emit_end) begin
      insert_status  <= kgrq_pkg::ST_STORED;
      found          <= (n != '0);
      keypoint_index <= (n != '0) ? 11'(pend) : 11'd0;
      last           <= 1'b1;
      truncated      <= trunc;
    end else if (cmd.hit) begin
      insert_status  <= kgrq_pkg::ST_STORED;
      found          <= 1'b1;
      keypoint_index <= 11'(pend);
      last           <= 1'b0;
      truncated      <= 1'b0;
    end
  end

endmodule

FILE: rtl/kgrq_ctrl.sv
// ----------------------------------------------------------------------------
// kgrq_ctrl
// Sequencer for clear, insert and radius query items.
// ----------------------------------------------------------------------------
module kgrq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           kind,
  input  kgrq_pkg::kgrq_stat_t stat,
  output kgrq_pkg::kgrq_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_INS_CHK = 5'd2;
  localparam logic [4:0] S_INS_MY  = 5'd3;
  localparam logic [4:0] S_INS_CY  = 5'd4;
  localparam logic [4:0] S_INS_RF  = 5'd5;
  localparam logic [4:0] S_INS_WF  = 5'd6;
  localparam logic [4:0] S_Q_M0    = 5'd7;
  localparam logic [4:0] S_Q_M1    = 5'd8;
  localparam logic [4:0] S_Q_M2    = 5'd9;
  localparam logic [4:0] S_Q_M3    = 5'd10;
  localparam logic [4:0] S_Q_M4    = 5'd11;
  localparam logic [4:0] S_Q_M5    = 5'd12;
  localparam logic [4:0] S_Q_RNG   = 5'd13;
  localparam logic [4:0] S_Q_CELL  = 5'd14;
  localparam logic [4:0] S_Q_ENT   = 5'd15;
  localparam logic [4:0] S_Q_KEY   = 5'd16;
  localparam logic [4:0] S_Q_ST    = 5'd17;
  localparam logic [4:0] S_Q_DX    = 5'd18;
  localparam logic [4:0] S_Q_CMP   = 5'd19;
  localparam logic [4:0] S_Q_END   = 5'd20;

  logic [4:0] state, state_next;

  // state register, reset starts the fill clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (kind)
            kgrq_pkg::KIND_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLR;
            end
            kgrq_pkg::KIND_INSERT: state_next = S_INS_CHK;
            kgrq_pkg::KIND_QUERY:  state_next = S_Q_M0;
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_INS_CHK: begin
        cmd.mul_sel = kgrq_pkg::MUL_X;
        if (stat.store_full) begin
          cmd.emit_ins   = 1'b1;
          cmd.ins_status = kgrq_pkg::ST_STORE_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.store_wr = 1'b1;
          state_next   = S_INS_MY;
        end
      end
      S_INS_MY: begin
        cmd.cap     = kgrq_pkg::CAP_CX;
        cmd.mul_sel = kgrq_pkg::MUL_Y;
        state_next  = S_INS_CY;
      end
      S_INS_CY: begin
        cmd.cap    = kgrq_pkg::CAP_CY;
        state_next = S_INS_RF;
      end
      S_INS_RF: begin
        if (stat.outside) begin
          cmd.emit_ins   = 1'b1;
          cmd.ins_status = kgrq_pkg::ST_OUTSIDE;
          cmd.idx_bump   = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.fill_rd = 1'b1;
          state_next  = S_INS_WF;
        end
      end
      S_INS_WF: begin
        cmd.emit_ins = 1'b1;
        cmd.idx_bump = 1'b1;
        if (stat.cell_full) begin
          cmd.ins_status = kgrq_pkg::ST_CELL_FULL;
        end else begin
          cmd.ins_status = kgrq_pkg::ST_STORED;
          cmd.ins_file   = 1'b1;
        end
        state_next = S_IDLE;
      end
      S_Q_M0: begin
        cmd.mul_sel = kgrq_pkg::MUL_X0;
        state_next  = S_Q_M1;
      end
      S_Q_M1: begin
        cmd.cap     = kgrq_pkg::CAP_C0X;
        cmd.mul_sel = kgrq_pkg::MUL_X1;
        state_next  = S_Q_M2;
      end
      S_Q_M2: begin
        cmd.cap     = kgrq_pkg::CAP_C1X;
        cmd.mul_sel = kgrq_pkg::MUL_Y0;
        state_next  = S_Q_M3;
      end
      S_Q_M3: begin
        cmd.cap     = kgrq_pkg::CAP_C0Y;
        cmd.mul_sel = kgrq_pkg::MUL_Y1;
        state_next  = S_Q_M4;
      end
      S_Q_M4: begin
        cmd.cap     = kgrq_pkg::CAP_C1Y;
        cmd.mul_sel = kgrq_pkg::MUL_R;
        state_next  = S_Q_M5;
      end
      S_Q_M5: begin
        cmd.cap       = kgrq_pkg::CAP_R2;
        cmd.walk_init = 1'b1;
        state_next    = S_Q_RNG;
      end
      S_Q_RNG: begin
        state_next = stat.range_empty ? S_Q_END : S_Q_CELL;
      end
      S_Q_CELL: begin
        cmd.fill_rd = 1'b1;
        state_next  = S_Q_ENT;
      end
      S_Q_ENT: begin
        if (stat.ent_more) begin
          cmd.ent_rd = 1'b1;
          state_next = S_Q_KEY;
        end else if (stat.walk_done) begin
          state_next = S_Q_END;
        end else begin
          cmd.cell_next = 1'b1;
          state_next    = S_Q_CELL;
        end
      end
      S_Q_KEY: begin
        state_next = S_Q_ST;
      end
      S_Q_ST: begin
        if (stat.lvl_ok) begin
          cmd.mul_sel = kgrq_pkg::MUL_DX;
          state_next  = S_Q_DX;
        end else begin
          cmd.e_next = 1'b1;
          state_next = S_Q_ENT;
        end
      end
      S_Q_DX: begin
        cmd.cap     = kgrq_pkg::CAP_DX2;
        cmd.mul_sel = kgrq_pkg::MUL_DY;
        state_next  = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (stat.in_radius && stat.hits_full) begin
          cmd.set_trunc = 1'b1;
          state_next    = S_Q_END;
        end else begin
          cmd.hit    = stat.in_radius;
          cmd.e_next = 1'b1;
          state_next = S_Q_ENT;
        end
      end
      S_Q_END: begin
        cmd.emit_end = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: sim/keypoint_grid_radius_query_top_test.sv
// ----------------------------------------------------------------------------
// keypoint_grid_radius_query_top_test
// Self-checking bench for the two-camera keypoint grid with radius queries.
// ----------------------------------------------------------------------------
// Directed tests cover grid edges, outside keypoints, full cells, level
// bounds, truncated queries and extreme grid settings. A random part then
// runs phases of inserts, queries and clears with and without sender gaps.
// A local model of both grids predicts every result, and a checker compares
// each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module keypoint_grid_radius_query_top_test;

  localparam int COLS     = kgrq_pkg::GRID_COLS_DEF;
  localparam int ROWS     = kgrq_pkg::GRID_ROWS_DEF;
  localparam int CAP      = kgrq_pkg::CELL_CAPACITY_DEF;
  localparam int MAX_KP   = kgrq_pkg::MAX_KEYPOINTS_DEF;
  localparam int HIT_CAP  = kgrq_pkg::MAX_HITS_DEF;
  localparam int NCELL    = COLS * ROWS;
  localparam int WD_LIMIT = 100000;

  // kind value with no meaning, ignored by the block
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic        hit;
    logic [10:0] index;
    logic        fin;
    logic        trunc;
  } grid_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = kgrq_pkg::KIND_CLEAR;
  logic               right_side = 1'b0;
  logic signed [15:0] x_pos = '0;
  logic signed [15:0] y_pos = '0;
  logic [2:0]         keypoint_level = '0;
  logic [14:0]        radius = '0;
  logic signed [3:0]  lowest_level = '0;
  logic signed [3:0]  highest_level = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = kgrq_pkg::REG_MIN_X;
  logic [15:0]        cfg_data = '0;
  logic               result_valid;
  logic [1:0]         insert_status;
  logic               found;
  logic [10:0]        keypoint_index;
  logic               last;
  logic               truncated;

  // model state of both grids
  longint      org_x, org_y, inv_w, inv_h;
  int          fill_cnt [2][NCELL];
  int          cell_list [2][NCELL][CAP];
  longint      kp_xs [2][MAX_KP];
  longint      kp_ys [2][MAX_KP];
  int          kp_lv [2][MAX_KP];
  int          next_free [2];
  grid_result_t pending_results [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int idle_pct = 0;
  int wd_count = 0;

  keypoint_grid_radius_query_top i_dut (.*);

  always #2 clk = ~clk;

  // cell number with floor toward minus infinity
  function automatic longint cell_num(longint diff, longint inv);
    longint p;
    p = diff * inv;
    return p >>> 20;
  endfunction

  function automatic void push_result(logic [1:0] st, logic h, int idx, logic f, logic t);
    grid_result_t r;
    r.status = st;
    r.hit = h;
    r.index = idx[10:0];
    r.fin = f;
    r.trunc = t;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // predict results of one transferred item and update the model
  function automatic void predict_grid(logic [1:0] k, logic s, longint x, longint y,
                                       int lvl, longint r, int minl, int maxl);
    longint cx, cy, c0x, c1x, c0y, c1y, dx, dy;
    int idx, c, f, kp, n;
    bit trunc;
    int hits [$];
    if (k == kgrq_pkg::KIND_CLEAR) begin
      foreach (fill_cnt[i, j]) fill_cnt[i][j] = 0;
      next_free[0] = 0;
      next_free[1] = 0;
    end else if (k == kgrq_pkg::KIND_INSERT) begin
      idx = next_free[s];
      if (idx >= MAX_KP) begin
        push_result(kgrq_pkg::ST_STORE_FULL, 1'b0, 0, 1'b1, 1'b0);
        return;
      end
      kp_xs[s][idx] = x;
      kp_ys[s][idx] = y;
      kp_lv[s][idx] = lvl;
      next_free[s] = idx + 1;
      cx = cell_num(x - org_x, inv_w);
      cy = cell_num(y - org_y, inv_h);
      if (cx < 0 || cx >= COLS || cy < 0 || cy >= ROWS) begin
        push_result(kgrq_pkg::ST_OUTSIDE, 1'b0, idx, 1'b1, 1'b0);
        return;
      end
      c = int'(cx) * ROWS + int'(cy);
      f = fill_cnt[s][c];
      if (f >= CAP) begin
        push_result(kgrq_pkg::ST_CELL_FULL, 1'b0, idx, 1'b1, 1'b0);
        return;
      end
      cell_list[s][c][f] = idx;
      fill_cnt[s][c] = f + 1;
      push_result(kgrq_pkg::ST_STORED, 1'b0, idx, 1'b1, 1'b0);
    end else if (k == kgrq_pkg::KIND_QUERY) begin
      c0x = cell_num(x - r - org_x, inv_w);
      c1x = cell_num(x + r - org_x, inv_w);
      c0y = cell_num(y - r - org_y, inv_h);
      c1y = cell_num(y + r - org_y, inv_h);
      if (c0x < 0) c0x = 0;
      if (c1x > COLS - 1) c1x = COLS - 1;
      if (c0y < 0) c0y = 0;
      if (c1y > ROWS - 1) c1y = ROWS - 1;
      trunc = 0;
      n = 0;
      // columns outer, rows inner, entries in filing order
      for (longint ix = c0x; ix <= c1x && !trunc; ix++) begin
        for (longint iy = c0y; iy <= c1y && !trunc; iy++) begin
          c = int'(ix) * ROWS + int'(iy);
          for (int e = 0; e < fill_cnt[s][c]; e++) begin
            kp = cell_list[s][c][e];
            if (minl >= 0 && kp_lv[s][kp] < minl) continue;
            if (maxl >= 0 && kp_lv[s][kp] > maxl) continue;
            dx = kp_xs[s][kp] - x;
            dy = kp_ys[s][kp] - y;
            if (dx * dx + dy * dy < r * r) begin
              if (n >= HIT_CAP) begin
                trunc = 1;
                break;
              end
              hits.insert(hits.size(), kp);
              n++;
            end
          end
        end
      end
      if (n == 0) push_result(kgrq_pkg::ST_STORED, 1'b0, 0, 1'b1, 1'b0);
      for (int i = 0; i < n; i++)
        push_result(kgrq_pkg::ST_STORED, 1'b1, hits[i], i == n - 1, (i == n - 1) && trunc);
    end
  endfunction

  // one item transfer, optional sender gap first
  task automatic send_item(logic [1:0] k, logic s, int x, int y, int lvl, int r,
                           int minl, int maxl);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    right_side <= s;
    x_pos <= x[15:0];
    y_pos <= y[15:0];
    keypoint_level <= lvl[2:0];
    radius <= r[14:0];
    lowest_level <= minl[3:0];
    highest_level <= maxl[3:0];
    do @(posedge clk); while (busy);
    predict_grid(k, s, longint'($signed(x[15:0])), longint'($signed(y[15:0])),
                 lvl & 7, longint'(r & 32'h7fff), int'($signed(minl[3:0])),
                 int'($signed(maxl[3:0])));
    items_sent++;
    if (k == kgrq_pkg::KIND_QUERY) queries_sent++;
  endtask

  // hold off until every expected result is in and the block is idle
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kgrq_pkg::REG_MIN_X: org_x = longint'($signed(value[15:0]));
      kgrq_pkg::REG_MIN_Y: org_y = longint'($signed(value[15:0]));
      kgrq_pkg::REG_W_INV: inv_w = longint'(value[15:0]);
      default:             inv_h = longint'(value[15:0]);
    endcase
  endtask

  task automatic set_grid(int mx, int my, int iw, int ih);
    write_reg(kgrq_pkg::REG_MIN_X, mx);
    write_reg(kgrq_pkg::REG_MIN_Y, my);
    write_reg(kgrq_pkg::REG_W_INV, iw);
    write_reg(kgrq_pkg::REG_H_INV, ih);
  endtask

  task automatic insert_kp(logic s, int x, int y, int lvl);
    send_item(kgrq_pkg::KIND_INSERT, s, x, y, lvl, 0, 0, 0);
  endtask

  task automatic query_kp(logic s, int x, int y, int r, int minl, int maxl);
    send_item(kgrq_pkg::KIND_QUERY, s, x, y, 0, r, minl, maxl);
  endtask

  task automatic clear_grids;
    send_item(kgrq_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
  endtask

  // result checker
  always @(posedge clk) begin
    grid_result_t e;
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result, index %0d", keypoint_index);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (insert_status !== e.status) begin
          $error("insert_status: expected %0d, got %0d", e.status, insert_status);
          errors++;
        end
        if (found !== e.hit) begin
          $error("found: expected %0d, got %0d", e.hit, found);
          errors++;
        end
        if (keypoint_index !== e.index) begin
          $error("keypoint_index: expected %0d, got %0d", e.index, keypoint_index);
          errors++;
        end
        if (last !== e.fin) begin
          $error("last: expected %0d, got %0d", e.fin, last);
          errors++;
        end
        if (truncated !== e.trunc) begin
          $error("truncated: expected %0d, got %0d", e.trunc, truncated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || rst) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("Some tests failed");
      $finish;
    end
  end

  // edges of the grid, outside keypoints and both sides
  task automatic test_insert_edges;
    set_grid(0, 0, 6554, 6554);
    insert_kp(0, 0, 0, 0);
    insert_kp(0, 10239, 7679, 7);
    insert_kp(1, 10240, 100, 3);
    insert_kp(1, -1, 100, 5);
    insert_kp(0, 32767, -32768, 2);
    insert_kp(1, -32768, 32767, 7);
    insert_kp(1, 500, 500, 4);
  endtask

  // radius zero, level bounds, empty range and an unused kind
  task automatic test_query_cases;
    query_kp(0, 0, 0, 0, -1, -1);
    query_kp(0, 0, 0, 1, -1, -1);
    query_kp(0, 5000, 4000, 32767, -1, -1);
    query_kp(1, 500, 500, 40, 4, 4);
    query_kp(1, 500, 500, 40, 5, -1);
    query_kp(1, 500, 500, 40, -1, 3);
    query_kp(1, 500, 500, 40, 6, 2);
    query_kp(0, -32768, -32768, 100, -1, -1);
    query_kp(0, 32767, 32767, 0, 0, 7);
    send_item(KIND_SPARE, 1, -1, -1, 7, 32767, -1, -1);
  endtask

  // seventeen keypoints in one cell overflow it
  task automatic test_cell_full;
    for (int i = 0; i < CAP + 1; i++) insert_kp(0, 2000 + i, 3000, i % 8);
    query_kp(0, 2000, 3000, 50, -1, -1);
  endtask

  // five full cells in a row give more hits than the cap
  task automatic test_truncation;
    clear_grids();
    for (int c = 0; c < 5; c++)
      for (int i = 0; i < CAP; i++) insert_kp(1, 80 + 160 * c + i, 80 + i, 1);
    query_kp(1, 400, 80, 2000, -1, -1);
    query_kp(1, 400, 80, 2000, 1, 1);
  endtask

  // zero and full inverse, extreme origins
  task automatic test_grid_extremes;
    set_grid(-32768, 32767, 0, 0);
    for (int i = 0; i < 4; i++) insert_kp(0, $urandom, $urandom, i);
    query_kp(0, 0, 0, 32767, -1, -1);
    set_grid(32767, -32768, 65535, 65535);
    insert_kp(0, 32767, -32768, 1);
    insert_kp(0, 32767 - 1, -32768 + 200, 2);
    query_kp(0, 32767, -32768, 300, -1, -1);
    set_grid(-32768, -32768, 65535, 65535);
    insert_kp(1, -32768 + 300, -32768 + 300, 6);
    query_kp(1, -32768 + 290, -32768 + 290, 20, -1, -1);
  endtask

  // random phases, mostly well-formed in-grid traffic
  task automatic test_random(int count, int pct, int mx, int my, int iw, int ih);
    int sel, x, y, r;
    logic s;
    set_grid(mx, my, iw, ih);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      s = $urandom_range(1);
      x = mx + $urandom_range(0, 10400) - 80;
      y = my + $urandom_range(0, 7800) - 60;
      r = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(600);
      if (n == count / 2) drain();
      if (sel < 2) clear_grids();
      else if (sel < 5) send_item(KIND_SPARE, s, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom);
      else if (sel < 50) insert_kp(s, x, y, $urandom_range(7));
      else if (sel < 58) insert_kp(s, $urandom, $urandom, $urandom);
      else if (sel < 92)
        query_kp(s, x, y, r, $urandom_range(8) - 1, $urandom_range(8) - 1);
      else query_kp(s, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    idle_pct = 0;
  endtask

  initial begin
    org_x = 0;
    org_y = 0;
    inv_w = 6554;
    inv_h = 6554;
    predict_grid(kgrq_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_insert_edges();
    test_query_cases();
    test_cell_full();
    test_truncation();
    test_grid_extremes();
    test_random(75, 0, 0, 0, 6554, 6554);
    test_random(75, 55, -5000, 3000, 6554, 7000);
    test_random(70, 32, 1200, -7000, 6000, 6554);
    test_random(70, 0, 0, 0, 6554, 6554);
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d items (%0d queries) and %0d results", items_sent, queries_sent,
             results_seen);
    $display("grid settings from zero to full inverse, sender gaps of 0, 32 and 55 percent");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
